// ===== hw/rtl/scpr_pkg.sv =====
// Shared types and constants for the second-chance page replacement block.
`default_nettype none
package scpr_pkg;

  localparam int CFG_W      = 5;   // frames_in_use register width
  localparam int PAGE_IN_W  = 16;  // page number port width
  localparam int IDX_OUT_W  = 4;   // frame index port width
  localparam int COUNT_W    = 32;  // fault counter width

  localparam logic [CFG_W-1:0] FIU_RESET = 5'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SWEEP
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_CLEAR,
    OP_HIT,
    OP_MISS,
    OP_SWEEP
  } cell_op_t;

  // per-cell links from the top level / left neighbor
  typedef struct packed {
    logic active;    // cell lies inside the active frame set
    logic is_home;   // cell 0: where the hand parks after clear or wrap
    logic stray;     // no active cell holds the hand
    logic tok_prev;  // hand handed over by the neighbor
    logic seen_in;   // an earlier cell already matched
  } cell_in_t;

  // per-cell status back to the top level / right neighbor
  typedef struct packed {
    logic tok;
    logic used;
    logic valid;
    logic hit_here;
    logic seen_out;
  } cell_out_t;

endpackage
`default_nettype wire

// ===== hw/rtl/scpr_cell.sv =====
// One frame cell: tag, valid mark, used bit and hand token.
`default_nettype none
module scpr_cell #(
  parameter int PAGE_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire scpr_pkg::cell_op_t   op,
  input  wire logic [PAGE_BITS-1:0] page,
  input  wire scpr_pkg::cell_in_t   link_in,
  output scpr_pkg::cell_out_t       link_out,
  output logic [PAGE_BITS-1:0]      tag
);
  import scpr_pkg::*;

  logic                 valid_r, valid_nxt;
  logic                 used_r, used_nxt;
  logic                 tok_r, tok_nxt;
  logic [PAGE_BITS-1:0] tag_r, tag_nxt;
  logic                 match;
  logic                 tok_norm;

  assign match    = link_in.active & valid_r & (tag_r == page);
  assign tok_norm = (tok_r & link_in.active) | (link_in.is_home & link_in.stray);

  always_comb begin
    valid_nxt = valid_r;
    used_nxt  = used_r;
    tok_nxt   = tok_r;
    tag_nxt   = tag_r;
    case (op)
      OP_CLEAR: begin
        valid_nxt = 1'b0;
        used_nxt  = 1'b0;
        tok_nxt   = link_in.is_home;
      end
      OP_HIT: begin
        tok_nxt = tok_norm;
        if (match && !link_in.seen_in) begin
          used_nxt = 1'b1;
        end
      end
      OP_MISS: begin
        tok_nxt = tok_norm;
      end
      OP_SWEEP: begin
        tok_nxt = link_in.tok_prev;
        if (tok_r) begin
          if (used_r) begin
            used_nxt = 1'b0;
          end else begin
            valid_nxt = 1'b1;
            used_nxt  = 1'b1;
            tag_nxt   = page;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      used_r  <= 1'b0;
      tok_r   <= link_in.is_home;
    end else begin
      valid_r <= valid_nxt;
      used_r  <= used_nxt;
      tok_r   <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_r <= tag_nxt;
  end

  assign link_out.tok      = tok_r;
  assign link_out.used     = used_r;
  assign link_out.valid    = valid_r;
  assign link_out.hit_here = match & ~link_in.seen_in;
  assign link_out.seen_out = link_in.seen_in | match;
  assign tag               = tag_r;

endmodule
`default_nettype wire

// ===== hw/rtl/second_chance_page_replacement_top.sv =====
// Top level: second-chance (clock) page replacement over a row of frame cells.
// A hit is resolved in LOOKUP; a miss goes on to SWEEP, where the hand clears one used
//   bit per cycle among the nf active frames until it reaches a clear one, which it loads.
// A new reference is taken only while idle; start is taken again in the strobe
//   cycle.
// The receiver cannot stall: out_valid is a one-cycle strobe.
// Reset (rst_n, synchronous): frames empty, hand at frame 0, count 0, nf 16.
`default_nettype none
module second_chance_page_replacement_top #(
  parameter int FRAMES    = 16,
  parameter int PAGE_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // command channel
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [scpr_pkg::PAGE_IN_W-1:0]      in_page_number,
  input  wire logic                                in_restart,
  // result channel
  output logic                                     out_valid,
  output logic                                     out_hit,
  output logic [scpr_pkg::IDX_OUT_W-1:0]           out_frame_index,
  output logic                                     out_evicted_valid,
  output logic [scpr_pkg::PAGE_IN_W-1:0]           out_evicted_page,
  output logic [scpr_pkg::COUNT_W-1:0]             out_fault_count,
  // configuration channel
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [scpr_pkg::CFG_W-1:0]          cfg_frames_in_use
);
  import scpr_pkg::*;

  localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  // width for frame counts: holds both the 5-bit register and FRAMES
  localparam int CMP_W = ($clog2(FRAMES + 1) > CFG_W) ? $clog2(FRAMES + 1) : CFG_W;

  state_t state_r, state_nxt;

  logic [CFG_W-1:0]     fiu_r;
  logic [PAGE_BITS-1:0] page_r;
  logic [COUNT_W-1:0]   faults_r, faults_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_hit_r, out_hit_nxt;
  logic [IDX_W-1:0]     out_idx_r, out_idx_nxt;
  logic                 out_ev_valid_r, out_ev_valid_nxt;
  logic [PAGE_BITS-1:0] out_ev_page_r, out_ev_page_nxt;
  logic [COUNT_W-1:0]   out_fault_r, out_fault_nxt;

  cell_op_t             op;
  logic                 accept;

  cell_in_t  link_in  [FRAMES];
  cell_out_t link_out [FRAMES];
  logic [PAGE_BITS-1:0] tags [FRAMES];

  logic [FRAMES-1:0] active;
  logic [FRAMES-1:0] last;

  logic [CMP_W-1:0] cfg_ext;
  logic [CMP_W-1:0] nf;

  // reductions over the row
  logic                 hit_any;
  logic                 stray;
  logic                 wrap_tok;
  logic                 sel_used;
  logic                 sel_valid;
  logic [PAGE_BITS-1:0] sel_tag;
  logic [IDX_W-1:0]     hand_idx;
  logic [IDX_W-1:0]     hit_idx;

  assign accept    = start & ~busy;
  assign cfg_ready = 1'b1;

  // effective frame count: 0 acts as 1, above FRAMES acts as FRAMES
  assign cfg_ext = CMP_W'(fiu_r);
  always_comb begin
    if (fiu_r == '0) begin
      nf = CMP_W'(1);
    end else if (cfg_ext > CMP_W'(FRAMES)) begin
      nf = CMP_W'(FRAMES);
    end else begin
      nf = cfg_ext;
    end
  end

  // ---------------------------------------------------------------------------
  // Cell row. The hit search runs as a priority chain (seen passes rightward);
  // the hand is a token passed one cell per cycle during a sweep, wrapping from the last
  // active cell back to cell 0.
  // ---------------------------------------------------------------------------
  genvar g;
  generate
    for (g = 0; g < FRAMES; g++) begin : g_cell
      assign active[g] = (CMP_W'(g) < nf);
      assign last[g]   = (CMP_W'(g) == (nf - CMP_W'(1)));

      assign link_in[g].active  = active[g];
      assign link_in[g].is_home = (g == 0);
      assign link_in[g].stray   = stray;
      if (g == 0) begin : g_first
        assign link_in[g].tok_prev = wrap_tok;
        assign link_in[g].seen_in  = 1'b0;
      end else begin : g_rest
        assign link_in[g].tok_prev = link_out[g-1].tok & ~last[g-1];
        assign link_in[g].seen_in  = link_out[g-1].seen_out;
      end

      scpr_cell #(
        .PAGE_BITS (PAGE_BITS)
      ) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (op),
        .page     (page_r),
        .link_in  (link_in[g]),
        .link_out (link_out[g]),
        .tag      (tags[g])
      );
    end
  endgenerate

  assign hit_any = link_out[FRAMES-1].seen_out;

  // OR-reductions: the hand token and the hit flag are one-hot
  always_comb begin
    wrap_tok  = 1'b0;
    stray     = 1'b1;
    sel_used  = 1'b0;
    sel_valid = 1'b0;
    sel_tag   = '0;
    hand_idx  = '0;
    hit_idx   = '0;
    for (int i = 0; i < FRAMES; i++) begin
      if (link_out[i].tok) begin
        sel_used  = sel_used | link_out[i].used;
        sel_valid = sel_valid | link_out[i].valid;
        sel_tag   = sel_tag | tags[i];
        hand_idx  = hand_idx | IDX_W'(i);
        if (last[i]) begin
          wrap_tok = 1'b1;
        end
        if (active[i]) begin
          stray = 1'b0;
        end
      end
      if (link_out[i].hit_here) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: IDLE -> LOOKUP (parallel compare) -> SWEEP (hand walk on a miss)
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        state_nxt = hit_any ? ST_IDLE : ST_SWEEP;
      end
      ST_SWEEP: begin
        if (!sel_used) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy = (state_r != ST_IDLE);
    op   = OP_NONE;
    case (state_r)
      ST_IDLE: begin
        if (start && in_restart) begin
          op = OP_CLEAR;
        end
      end
      ST_LOOKUP: begin
        op = hit_any ? OP_HIT : OP_MISS;
      end
      ST_SWEEP: begin
        op = OP_SWEEP;
      end
      default: begin
        op = OP_NONE;
      end
    endcase
  end

  // fault counter and result word
  always_comb begin
    faults_nxt       = faults_r;
    out_valid_nxt    = 1'b0;
    out_hit_nxt      = out_hit_r;
    out_idx_nxt      = out_idx_r;
    out_ev_valid_nxt = out_ev_valid_r;
    out_ev_page_nxt  = out_ev_page_r;
    out_fault_nxt    = out_fault_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_restart) begin
          faults_nxt = '0;
        end
      end
      ST_LOOKUP: begin
        if (hit_any) begin
          out_valid_nxt    = 1'b1;
          out_hit_nxt      = 1'b1;
          out_idx_nxt      = hit_idx;
          out_ev_valid_nxt = 1'b0;
          out_ev_page_nxt  = '0;
          out_fault_nxt    = faults_r;
        end else if (faults_r != '1) begin
          faults_nxt = faults_r + COUNT_W'(1);
        end
      end
      ST_SWEEP: begin
        if (!sel_used) begin
          out_valid_nxt    = 1'b1;
          out_hit_nxt      = 1'b0;
          out_idx_nxt      = hand_idx;
          out_ev_valid_nxt = sel_valid;
          out_ev_page_nxt  = sel_valid ? sel_tag : '0;
          out_fault_nxt    = faults_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fiu_r       <= FIU_RESET;
      faults_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      faults_r    <= faults_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        fiu_r <= cfg_frames_in_use;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      page_r <= PAGE_BITS'(in_page_number);
    end
    out_hit_r      <= out_hit_nxt;
    out_idx_r      <= out_idx_nxt;
    out_ev_valid_r <= out_ev_valid_nxt;
    out_ev_page_r  <= out_ev_page_nxt;
    out_fault_r    <= out_fault_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_frame_index   = IDX_OUT_W'(out_idx_r);
  assign out_evicted_valid = out_ev_valid_r;
  assign out_evicted_page  = PAGE_IN_W'(out_ev_page_r);
  assign out_fault_count   = out_fault_r;

endmodule
`default_nettype wire

// ===== tb/replacement_checker.sv =====
// Checker for the page replacement block: tracks frames, predicts each result word, compares.
module replacement_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  logic [scpr_pkg::PAGE_IN_W-1:0] in_page_number,
  input  logic                           in_restart,
  input  logic                           out_valid,
  input  logic                           out_hit,
  input  logic [scpr_pkg::IDX_OUT_W-1:0] out_frame_index,
  input  logic                           out_evicted_valid,
  input  logic [scpr_pkg::PAGE_IN_W-1:0] out_evicted_page,
  input  logic [scpr_pkg::COUNT_W-1:0]   out_fault_count,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [scpr_pkg::CFG_W-1:0]     cfg_frames_in_use,
  output int unsigned                    mismatch_count,
  output int unsigned                    results_due
);
  import scpr_pkg::*;

  localparam int NUM_FRAMES = 16;

  typedef struct packed {
    logic                 hit;
    logic [IDX_OUT_W-1:0] frame;
    logic                 ev_valid;
    logic [PAGE_IN_W-1:0] ev_page;
    logic [COUNT_W-1:0]   fault_total;
  } lookup_result_t;

  logic [PAGE_IN_W-1:0] tag [NUM_FRAMES];
  bit                   resident [NUM_FRAMES];
  bit                   referenced [NUM_FRAMES];
  int unsigned          hand;
  logic [COUNT_W-1:0]   faults;
  logic [CFG_W-1:0]     frames_in_use;
  lookup_result_t       pending_results [$];

  function automatic void empty_frames();
    for (int f = 0; f < NUM_FRAMES; f++) begin
      resident[f]   = 1'b0;
      referenced[f] = 1'b0;
    end
    hand   = 0;
    faults = '0;
  endfunction

  function automatic int unsigned step_hand(int unsigned h, int unsigned nf);
    return (h + 1 >= nf) ? 0 : h + 1;
  endfunction

  function automatic lookup_result_t predict_reference(logic [PAGE_IN_W-1:0] page,
                                                       logic restart);
    lookup_result_t r;
    int unsigned    nf;
    int             slot;
    r    = '0;
    slot = -1;
    if (restart) empty_frames();
    nf = (frames_in_use == 0) ? 1 :
         (frames_in_use > NUM_FRAMES) ? NUM_FRAMES : frames_in_use;
    if (hand >= nf) hand = 0;
    for (int f = 0; f < nf; f++)
      if (slot < 0 && resident[f] && tag[f] == page) slot = f;
    if (slot >= 0) begin
      referenced[slot] = 1'b1;
      r.hit = 1'b1;
    end else begin
      if (faults != '1) faults = faults + 1'b1;
      // second chance: clear set used bits until a clear one comes up
      for (int f = 0; f < nf && referenced[hand]; f++) begin
        referenced[hand] = 1'b0;
        hand = step_hand(hand, nf);
      end
      slot = hand;
      if (resident[slot]) begin
        r.ev_valid = 1'b1;
        r.ev_page  = tag[slot];
      end
      tag[slot]        = page;
      resident[slot]   = 1'b1;
      referenced[slot] = 1'b1;
      hand = step_hand(hand, nf);
    end
    r.frame       = IDX_OUT_W'(slot);
    r.fault_total = faults;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic compare_field(string field, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s mismatch: got %0h, expected %0h", field, got, want));
  endtask

  always @(posedge clk) begin : monitor
    lookup_result_t want;
    if (!rst_n) begin
      empty_frames();
      frames_in_use = FIU_RESET;
      pending_results.delete();
    end else begin
      // result word first: one may retire in the same cycle a new reference is taken
      if (out_valid) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result word with nothing pending");
        end else begin
          want = pending_results.pop_front();
          compare_field("hit", out_hit, want.hit);
          compare_field("frame_index", out_frame_index, want.frame);
          compare_field("evicted_valid", out_evicted_valid, want.ev_valid);
          compare_field("evicted_page", out_evicted_page, want.ev_page);
          compare_field("fault_count", out_fault_count, want.fault_total);
        end
      end
      if (cfg_valid && cfg_ready) frames_in_use = cfg_frames_in_use;
      if (start && !busy)
        pending_results.push_back(predict_reference(in_page_number, in_restart));
    end
    results_due <= pending_results.size();
  end

endmodule

// ===== tb/tb_top.sv =====
// Stimulus and verdict for the second-chance page replacement block.
module tb_top;
  import scpr_pkg::*;

  // Frame count settings visited by the random phases; 0 and anything above 16
  // exercise the clamping, and the drops from 16/17 down to smaller counts
  // leave the hand outside the active set. Index 8 is replaced at run time.
  localparam int NUM_PHASES = 12;
  localparam logic [CFG_W-1:0] FRAME_SETTINGS [NUM_PHASES] = '{
    5'd1, 5'd0, 5'd5, 5'd31, 5'd16, 5'd2, 5'd17, 5'd9, 5'd3, 5'd12, 5'd7, 5'd16
  };
  localparam int PHASE_ITEMS = 145;
  localparam int HOT_PAGES   = 20;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic [PAGE_IN_W-1:0] in_page_number = '0;
  logic                 in_restart = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_W-1:0]     cfg_frames_in_use = '0;

  logic                 busy;
  logic                 out_valid;
  logic                 out_hit;
  logic [IDX_OUT_W-1:0] out_frame_index;
  logic                 out_evicted_valid;
  logic [PAGE_IN_W-1:0] out_evicted_page;
  logic [COUNT_W-1:0]   out_fault_count;
  logic                 cfg_ready;

  int unsigned          mismatch_count;
  int unsigned          results_due;

  // Small working set of pages, so references hit often; it is only partly
  // refreshed between phases, so frames parked outside a shrunken active set
  // still hold pages that come back once the set grows again.
  logic [PAGE_IN_W-1:0] hot_pages [HOT_PAGES];
  int unsigned          idle_pct;

  always #5 clk = ~clk;

  second_chance_page_replacement_top uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_page_number    (in_page_number),
    .in_restart        (in_restart),
    .out_valid         (out_valid),
    .out_hit           (out_hit),
    .out_frame_index   (out_frame_index),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_fault_count   (out_fault_count),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_frames_in_use (cfg_frames_in_use)
  );

  replacement_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_page_number    (in_page_number),
    .in_restart        (in_restart),
    .out_valid         (out_valid),
    .out_hit           (out_hit),
    .out_frame_index   (out_frame_index),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_fault_count   (out_fault_count),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_frames_in_use (cfg_frames_in_use),
    .mismatch_count    (mismatch_count),
    .results_due       (results_due)
  );

  // Random sender gap. Called right after a word is taken, so the gap overlaps
  // the block's lookup or sweep at varying points. Inputs carry junk while
  // start is low; the block must ignore them.
  task automatic maybe_idle();
    if ($urandom_range(0, 99) < idle_pct) begin
      start          <= 1'b0;
      in_page_number <= PAGE_IN_W'($urandom);
      in_restart     <= 1'($urandom);
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // One reference word. start stays high into the next word when no gap
  // follows, so it is never dropped and raised in the same step.
  task automatic issue_reference(logic [PAGE_IN_W-1:0] page, logic restart);
    start          <= 1'b1;
    in_page_number <= page;
    in_restart     <= restart;
    do @(posedge clk); while (busy);
    maybe_idle();
  endtask

  // Mostly working-set pages, some fully random ones, rare restarts.
  task automatic random_reference(int unsigned window);
    logic [PAGE_IN_W-1:0] page;
    if ($urandom_range(0, 99) < 8) page = PAGE_IN_W'($urandom);
    else                           page = hot_pages[$urandom_range(0, window - 1)];
    issue_reference(page, $urandom_range(0, 99) < 2);
  endtask

  // Register write only while idle: every reference yields a result word, so
  // nothing outstanding means the block is done. Sampled on the falling edge
  // so the checker's count has settled.
  task automatic set_frames(logic [CFG_W-1:0] count);
    start <= 1'b0;
    do @(negedge clk); while (results_due != 0);
    @(posedge clk);
    cfg_valid         <= 1'b1;
    cfg_frames_in_use <= count;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [CFG_W-1:0] setting;
    int unsigned      nf;
    int unsigned      window;

    hot_pages[0] = '0;
    hot_pages[1] = '1;
    for (int i = 2; i < HOT_PAGES; i++) hot_pages[i] = PAGE_IN_W'($urandom);
    idle_pct = 30;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset frame count of 16.
    issue_reference(16'h0000, 1'b0);   // miss into an empty frame
    issue_reference(16'hFFFF, 1'b0);
    issue_reference(16'h0000, 1'b0);   // hits leave the hand alone
    issue_reference(16'hFFFF, 1'b0);
    for (int i = 1; i <= 14; i++)      // fill the rest, hand wraps to frame 0
      issue_reference(PAGE_IN_W'(i), 1'b0);
    issue_reference(16'h8000, 1'b0);   // all used bits set: full sweep, evicts frame 0
    issue_reference(16'hFFFF, 1'b0);   // hit re-arms a cleared used bit
    issue_reference(16'h5555, 1'b0);   // sweep passes frame 1, evicts frame 2
    issue_reference(16'hAAAA, 1'b1);   // restart: empty frames, count back to 1
    issue_reference(16'hAAAA, 1'b0);
    set_frames(5'd1);                  // hand now beyond the active set
    issue_reference(16'h1234, 1'b0);
    issue_reference(16'hAAAA, 1'b0);

    // Random phases, one per frame count setting. The last one runs without
    // sender gaps. Saturation of the fault count lies far beyond any run.
    for (int p = 0; p < NUM_PHASES; p++) begin
      setting = (p == 8) ? CFG_W'($urandom) : FRAME_SETTINGS[p];
      set_frames(setting);
      nf = (setting == 0) ? 1 : (setting > 16) ? 16 : setting;
      for (int i = 2; i < HOT_PAGES; i++)
        if ($urandom_range(0, 3) == 0) hot_pages[i] = PAGE_IN_W'($urandom);
      window = nf + $urandom_range(0, 4);
      window = (window > 1) ? window - 1 : 1;
      if (window > HOT_PAGES) window = HOT_PAGES;
      case ($urandom_range(0, 2))
        0:       idle_pct = 0;
        1:       idle_pct = 15;
        default: idle_pct = 50;
      endcase
      if (p == NUM_PHASES - 1) idle_pct = 0;
      repeat (PHASE_ITEMS) random_reference(window);
    end

    // Drain, then watch a while longer for stray result words.
    start <= 1'b0;
    do @(negedge clk); while (results_due != 0);
    repeat (24) @(posedge clk);
    if (mismatch_count == 0 && results_due == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin
    #5000000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
